>>> hw/rtl/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the plane edge extension block.
// ----------------------------------------------------------------------------
package pee_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_PAD    = 63;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);

    localparam int DIM_W = 13;
    localparam int PAD_W = 6;
    localparam int PIX_W = 8;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        CFG_DISPLAY_WIDTH  = 2'd0,
        CFG_DISPLAY_HEIGHT = 2'd1,
        CFG_RIGHT_PAD      = 2'd2,
        CFG_BOTTOM_PAD     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_DISPLAY = 2'd0,
        PH_FILL    = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FILL   = 1'b1;

    localparam logic ST_VALID   = 1'b0;
    localparam logic ST_IGNORED = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [DIM_W-1:0] column;
        logic [DIM_W-1:0] row;
        logic [PAD_W-1:0] repeat_count;
        logic             fin;
        logic             status;
    } cmd_t;

endpackage

>>> hw/rtl/pee_queue.sv
// ----------------------------------------------------------------------------
// pee_queue
// Short command queue between the classifying front end and the run engine.
// ----------------------------------------------------------------------------
module pee_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pee_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output pee_pkg::cmd_t head_cmd
);

    pee_pkg::cmd_t                  mem_reg [pee_pkg::Q_DEPTH];
    logic [pee_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [pee_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [pee_pkg::Q_CNT_W-1:0]    count_reg, count_next;
    logic                           do_push, do_pop;

    assign full       = (count_reg == pee_pkg::Q_CNT_W'(pee_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hw/rtl/pee_front.sv
// ----------------------------------------------------------------------------
// pee_front
// Configuration, raster position tracking, line store and item classification.
// ----------------------------------------------------------------------------
module pee_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [pee_pkg::DIM_W-1:0]    cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_opcode,
    input  logic [pee_pkg::PIX_W-1:0]    in_sample,
    output logic                         cmd_valid,
    output pee_pkg::cmd_t                cmd,
    input  logic                         queue_full
);

    logic [pee_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [pee_pkg::PAD_W-1:0] rpad_reg, bpad_reg;
    logic [pee_pkg::DIM_W-1:0] clamped;

    pee_pkg::phase_t           phase_reg, phase_next;
    logic [pee_pkg::DIM_W-1:0] col_reg, col_next;
    logic [pee_pkg::DIM_W-1:0] row_reg, row_next;
    logic [pee_pkg::PIX_W-1:0] last_sample_reg, last_sample_next;

    logic [pee_pkg::PIX_W-1:0] row_store [pee_pkg::MAX_WIDTH];
    logic [pee_pkg::PIX_W-1:0] rd_data_reg;

    logic                      stage_valid_reg, stage_valid_next;
    pee_pkg::cmd_t             stage_cmd_reg, stage_cmd_next;
    logic                      use_store_reg, use_store_next;

    logic                      accept, is_disp, is_fill;
    logic [pee_pkg::DIM_W-1:0] col_inc, row_inc, fill_w, fill_h;
    logic [pee_pkg::ADDR_W-1:0] addr;

    assign in_ready = !stage_valid_reg || !queue_full;
    assign accept   = in_valid && in_ready;
    assign is_disp  = (phase_reg == pee_pkg::PH_DISPLAY) && (in_opcode == pee_pkg::OP_SAMPLE);
    assign is_fill  = (phase_reg == pee_pkg::PH_FILL) && (in_opcode == pee_pkg::OP_FILL);
    assign col_inc  = col_reg + 1'b1;
    assign row_inc  = row_reg + 1'b1;
    assign fill_w   = width_reg + pee_pkg::DIM_W'(rpad_reg);
    assign fill_h   = height_reg + pee_pkg::DIM_W'(bpad_reg);
    assign addr     = col_reg[pee_pkg::ADDR_W-1:0];

    assign cmd_valid = stage_valid_reg;
    always_comb begin
        cmd = stage_cmd_reg;
        if (use_store_reg) begin
            cmd.pixel = rd_data_reg;
        end
    end

    always_comb begin
        if (cfg_wdata == '0) begin
            clamped = pee_pkg::DIM_W'(1);
        end else if ({1'b0, cfg_wdata} > (pee_pkg::DIM_W + 1)'(pee_pkg::MAX_WIDTH)) begin
            clamped = pee_pkg::DIM_W'(pee_pkg::MAX_WIDTH);
        end else begin
            clamped = cfg_wdata;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        last_sample_next = last_sample_reg;
        stage_valid_next = stage_valid_reg && queue_full;
        stage_cmd_next   = stage_cmd_reg;
        use_store_next   = use_store_reg;

        if (accept) begin
            stage_valid_next            = 1'b1;
            use_store_next              = 1'b0;
            stage_cmd_next.pixel        = '0;
            stage_cmd_next.column       = '0;
            stage_cmd_next.row          = '0;
            stage_cmd_next.repeat_count = '0;
            stage_cmd_next.fin          = 1'b0;
            stage_cmd_next.status       = pee_pkg::ST_IGNORED;

            if (is_disp) begin
                last_sample_next      = in_sample;
                stage_cmd_next.pixel  = in_sample;
                stage_cmd_next.column = col_reg;
                stage_cmd_next.row    = row_reg;
                stage_cmd_next.status = pee_pkg::ST_VALID;
                if (col_inc != width_reg) begin
                    col_next = col_inc;
                end else begin
                    stage_cmd_next.repeat_count = rpad_reg;
                    stage_cmd_next.fin          = (row_inc == height_reg) && (bpad_reg == '0);
                    col_next                    = '0;
                    row_next                    = row_inc;
                    if (row_inc == height_reg) begin
                        phase_next = (bpad_reg == '0) ? pee_pkg::PH_DONE : pee_pkg::PH_FILL;
                    end
                end
            end else if (is_fill) begin
                use_store_next        = (col_reg < width_reg);
                stage_cmd_next.pixel  = last_sample_reg;
                stage_cmd_next.column = col_reg;
                stage_cmd_next.row    = row_reg;
                stage_cmd_next.status = pee_pkg::ST_VALID;
                if (col_inc == fill_w) begin
                    col_next = '0;
                    row_next = row_inc;
                    if (row_inc == fill_h) begin
                        phase_next         = pee_pkg::PH_DONE;
                        stage_cmd_next.fin = 1'b1;
                    end
                end else begin
                    col_next = col_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg       <= pee_pkg::DIM_W'(1);
            height_reg      <= pee_pkg::DIM_W'(1);
            rpad_reg        <= '0;
            bpad_reg        <= '0;
            phase_reg       <= pee_pkg::PH_DISPLAY;
            col_reg         <= '0;
            row_reg         <= '0;
            last_sample_reg <= '0;
            stage_valid_reg <= 1'b0;
        end else begin
            last_sample_reg <= last_sample_next;
            stage_valid_reg <= stage_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    pee_pkg::CFG_DISPLAY_WIDTH:  width_reg  <= clamped;
                    pee_pkg::CFG_DISPLAY_HEIGHT: height_reg <= clamped;
                    pee_pkg::CFG_RIGHT_PAD:      rpad_reg   <= cfg_wdata[pee_pkg::PAD_W-1:0];
                    pee_pkg::CFG_BOTTOM_PAD:     bpad_reg   <= cfg_wdata[pee_pkg::PAD_W-1:0];
                    default:                     width_reg  <= width_reg;
                endcase
                phase_reg <= pee_pkg::PH_DISPLAY;
                col_reg   <= '0;
                row_reg   <= '0;
            end else begin
                phase_reg <= phase_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        stage_cmd_reg <= stage_cmd_next;
        use_store_reg <= use_store_next;
        if (accept && is_disp) begin
            row_store[addr] <= in_sample;
        end
        if (accept) begin
            rd_data_reg <= row_store[addr];
        end
    end

endmodule

>>> hw/rtl/pee_back.sv
// ----------------------------------------------------------------------------
// pee_back
// Run engine: expands queued commands into output pixels, one per transfer.
// ----------------------------------------------------------------------------
module pee_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         head_valid,
    input  pee_pkg::cmd_t                head_cmd,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pee_pkg::PIX_W-1:0]    out_pixel,
    output logic [pee_pkg::DIM_W-1:0]    out_column,
    output logic [pee_pkg::DIM_W-1:0]    out_row,
    output logic                         out_last,
    output logic                         out_done,
    output logic                         out_status
);

    logic                      active_reg, active_next;
    logic [pee_pkg::PIX_W-1:0] pix_reg, pix_next;
    logic [pee_pkg::DIM_W-1:0] col_reg, col_next;
    logic [pee_pkg::DIM_W-1:0] row_reg, row_next;
    logic [pee_pkg::PAD_W-1:0] rem_reg, rem_next;
    logic                      fin_reg, fin_next;
    logic                      status_reg, status_next;
    logic                      run_end;

    assign run_end    = (rem_reg == '0);
    assign pop        = head_valid && (!active_reg || (out_ready && run_end));
    assign out_valid  = active_reg;
    assign out_pixel  = pix_reg;
    assign out_column = col_reg;
    assign out_row    = row_reg;
    assign out_last   = run_end;
    assign out_done   = fin_reg && run_end;
    assign out_status = status_reg;

    always_comb begin
        active_next = active_reg;
        pix_next    = pix_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        rem_next    = rem_reg;
        fin_next    = fin_reg;
        status_next = status_reg;
        if (pop) begin
            active_next = 1'b1;
            pix_next    = head_cmd.pixel;
            col_next    = head_cmd.column;
            row_next    = head_cmd.row;
            rem_next    = head_cmd.repeat_count;
            fin_next    = head_cmd.fin;
            status_next = head_cmd.status;
        end else if (active_reg && out_ready) begin
            if (run_end) begin
                active_next = 1'b0;
            end else begin
                col_next = col_reg + 1'b1;
                rem_next = rem_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg    <= pix_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        rem_reg    <= rem_next;
        fin_reg    <= fin_next;
        status_reg <= status_next;
    end

endmodule

>>> hw/rtl/plane_edge_extension_top.sv
// ----------------------------------------------------------------------------
// plane_edge_extension_top
// Border-replicate padding of one 8-bit image plane streamed in raster order.
// ----------------------------------------------------------------------------
// Display samples are taken one per cycle and each yields one pixel; the last
// sample of a row yields right_pad+1 pixels, paced by the run counter in the
// back end, while the front end keeps taking input until the four-entry
// command queue fills. Fill ticks and ignored items yield one result each, one
// per cycle while m_tready is high. A configuration write restarts the plane
// at row 0, column 0.
// ----------------------------------------------------------------------------
module plane_edge_extension_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // sample[7:0]
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel[7:0], column[20:8], row[33:21], zero[39:34]
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // plane_done[0], status[1]
);

    logic          cmd_valid, queue_full, head_valid, pop;
    pee_pkg::cmd_t cmd, head_cmd;
    logic [7:0]    pixel;
    logic [12:0]   column, row;
    logic          plane_done, status;

    pee_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_opcode  (s_tuser[0]),
        .in_sample  (s_tdata),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .queue_full (queue_full)
    );

    pee_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (cmd_valid),
        .push_cmd   (cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    pee_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixel  (pixel),
        .out_column (column),
        .out_row    (row),
        .out_last   (m_tlast),
        .out_done   (plane_done),
        .out_status (status)
    );

    assign m_tdata = {6'b0, row, column, pixel};
    assign m_tuser = {status, plane_done};

endmodule
